[sv/quaternion_to_euler_yaw_unwrap_macros.svh]
// assertion macros for the quaternion to euler yaw unwrap block
`ifndef QUATERNION_TO_EULER_YAW_UNWRAP_MACROS_SVH
`define QUATERNION_TO_EULER_YAW_UNWRAP_MACROS_SVH

// same-cycle implication, off while reset is held
`define QEY_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define QEY_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also covers reset itself
`define QEY_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/qey_pkg.sv]
// shared types, constants and the arctangent table for the euler angle block
package qey_pkg;

    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 8;

    localparam int TW         = 35;  // sine and cosine terms, q28
    localparam int XW         = 38;  // cordic x and y with gain headroom
    localparam int AW         = 26;  // cordic angle, q16 degrees
    localparam int CNT_W      = 5;   // step counter
    localparam int SQW        = 58;  // square root working width
    localparam int MUL_STEPS  = 9;
    localparam int SQRT_STEPS = 29;

    localparam longint DEG_GAIN_Q24 = 64'sd961263669;

    // product schedule of the shared multiplier
    localparam logic [CNT_W-1:0] P_WX = 5'd0;
    localparam logic [CNT_W-1:0] P_YZ = 5'd1;
    localparam logic [CNT_W-1:0] P_XX = 5'd2;
    localparam logic [CNT_W-1:0] P_YY = 5'd3;
    localparam logic [CNT_W-1:0] P_WY = 5'd4;
    localparam logic [CNT_W-1:0] P_ZX = 5'd5;
    localparam logic [CNT_W-1:0] P_WZ = 5'd6;
    localparam logic [CNT_W-1:0] P_XY = 5'd7;
    localparam logic [CNT_W-1:0] P_ZZ = 5'd8;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic               rezero_yaw;
    } t_in;

    typedef struct packed {
        logic signed [16:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [31:0] relative_yaw;
        logic               pitch_clamped;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SQ, S_SQLD, S_SQRT, S_CLD, S_CORD, S_STORE, S_UPD, S_FIN
    } t_state;

    typedef enum logic [1:0] {A_ROLL, A_PITCH, A_YAW} t_ang;

    typedef struct packed {
        logic             load;
        logic             mul_en;
        logic             acc_en;
        logic             sq_en;
        logic             sqrt_ld;
        logic             sqrt_step;
        logic             cor_ld;
        logic             cor_step;
        logic             store_en;
        logic             upd_en;
        logic             out_load;
        t_ang             sel;
        logic [CNT_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic clamped;
    } t_sts;

    // atan(2^-i) in q16 degrees
    function automatic logic signed [AW-1:0] atan_entry(input logic [CNT_W-1:0] i);
        logic [63:0] v;
        v = '0;
        case (i)
            5'd0:    v = 64'd2949120;
            5'd1:    v = 64'd1740967;
            5'd2:    v = 64'd919879;
            5'd3:    v = 64'd466945;
            5'd4:    v = 64'd234379;
            5'd5:    v = 64'd117304;
            5'd6:    v = 64'd58666;
            5'd7:    v = 64'd29335;
            default: v = (64'(DEG_GAIN_Q24) + (64'd1 << (i + 7))) >> (i + 8);
        endcase
        return $signed(v[AW-1:0]);
    endfunction

endpackage

[sv/qey_cordic.sv]
// vectoring cordic, one micro-rotation per step, angle in q16 degrees
module qey_cordic (
    input  logic                           i_clk,
    input  logic                           i_load,
    input  logic                           i_step,
    input  logic [qey_pkg::CNT_W-1:0]      i_idx,
    input  logic signed [qey_pkg::XW-1:0]  i_y,
    input  logic signed [qey_pkg::XW-1:0]  i_x,
    output logic signed [qey_pkg::AW-1:0]  o_ang
);
    import qey_pkg::*;

    localparam logic signed [AW-1:0] DEG90 = AW'(90 <<< 16);

    logic signed [XW-1:0] r_x, r_y, n_x, n_y, sh_x, sh_y;
    logic signed [AW-1:0] r_ang, n_ang;
    logic                 r_zero, n_zero;

    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_ang  = r_ang;
        n_zero = r_zero;
        sh_x   = r_x >>> i_idx;
        sh_y   = r_y >>> i_idx;
        if (i_load) begin
            n_zero = (i_x == '0) && (i_y == '0);
            // left half plane: quarter turn first
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    n_x   = i_y;
                    n_y   = -i_x;
                    n_ang = DEG90;
                end else begin
                    n_x   = -i_y;
                    n_y   = i_x;
                    n_ang = -DEG90;
                end
            end else begin
                n_x   = i_x;
                n_y   = i_y;
                n_ang = '0;
            end
        end else if (i_step) begin
            if (r_y > 0) begin
                n_x   = r_x + sh_y;
                n_y   = r_y - sh_x;
                n_ang = r_ang + atan_entry(i_idx);
            end else begin
                n_x   = r_x - sh_y;
                n_y   = r_y + sh_x;
                n_ang = r_ang - atan_entry(i_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_ang  <= n_ang;
        r_zero <= n_zero;
    end

    assign o_ang = r_zero ? '0 : r_ang;

endmodule

[sv/qey_ctrl.sv]
// sequencer for products, optional square root, up to three cordic passes and yaw update
module qey_ctrl #(
    parameter int CORDIC_STEPS = qey_pkg::CORDIC_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  qey_pkg::t_sts i_sts,
    output qey_pkg::t_cmd o_cmd
);
    import qey_pkg::*;

    localparam logic [CNT_W-1:0] MUL_END  = CNT_W'(MUL_STEPS);
    localparam logic [CNT_W-1:0] SQRT_END = CNT_W'(SQRT_STEPS - 1);
    localparam logic [CNT_W-1:0] COR_END  = CNT_W'(CORDIC_STEPS - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_ang             r_sel, n_sel;
    logic             r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_sel    <= A_ROLL;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_sel    <= n_sel;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_sel     = r_sel;
        n_ovalid  = r_ovalid;
        o_cmd     = '0;
        o_cmd.sel = r_sel;
        o_cmd.idx = r_cnt;
        o_ready   = 1'b0;
        if (i_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = (r_cnt != MUL_END);
                o_cmd.acc_en = (r_cnt != '0);
                if (r_cnt == MUL_END) begin
                    n_cnt   = '0;
                    n_sel   = A_ROLL;
                    n_state = i_sts.clamped ? S_CLD : S_SQ;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SQ: begin
                o_cmd.sq_en = 1'b1;
                n_state     = S_SQLD;
            end
            S_SQLD: begin
                o_cmd.sqrt_ld = 1'b1;
                n_cnt         = '0;
                n_state       = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == SQRT_END) begin
                    n_sel   = A_ROLL;
                    n_state = S_CLD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CLD: begin
                o_cmd.cor_ld = 1'b1;
                n_cnt        = '0;
                n_state      = S_CORD;
            end
            S_CORD: begin
                o_cmd.cor_step = 1'b1;
                if (r_cnt == COR_END) begin
                    n_state = S_STORE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_STORE: begin
                o_cmd.store_en = 1'b1;
                case (r_sel)
                    A_ROLL: begin
                        n_sel   = i_sts.clamped ? A_YAW : A_PITCH;
                        n_state = S_CLD;
                    end
                    A_PITCH: begin
                        n_sel   = A_YAW;
                        n_state = S_CLD;
                    end
                    default: begin
                        n_state = S_UPD;
                    end
                endcase
            end
            S_UPD: begin
                o_cmd.upd_en = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid = r_ovalid;

endmodule

[sv/qey_dp.sv]
// datapath: products, square root, cordic, rounding, yaw unwrap, result register
module qey_dp #(
    parameter int ANGLE_FRAC_BITS = qey_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  qey_pkg::t_cmd i_cmd,
    input  qey_pkg::t_in  i_data,
    output qey_pkg::t_sts o_sts,
    output qey_pkg::t_out o_data
);
    import qey_pkg::*;

    localparam int SH = 16 - ANGLE_FRAC_BITS;
    localparam int OW = AW + 1;
    localparam int DW = OW + 2;
    localparam logic signed [OW-1:0] A180 = OW'(180 <<< ANGLE_FRAC_BITS);
    localparam logic signed [OW-1:0] A90  = OW'(90 <<< ANGLE_FRAC_BITS);
    localparam logic signed [TW-1:0] ONE  = TW'(1 <<< 28);
    localparam logic signed [33:0] S_MAX  = 34'sd2147483647;
    localparam logic signed [33:0] S_MIN  = -34'sd2147483648;

    t_in                  r_in;
    logic signed [31:0]   r_prod, prod_c;
    logic [CNT_W-1:0]     r_pidx;
    logic signed [15:0]   mul_a, mul_b;
    logic signed [32:0]   r_a_sr, r_a_cr, r_a_sp, r_a_sy, r_a_cy;
    logic signed [32:0]   n_a_sr, n_a_cr, n_a_sp, n_a_sy, n_a_cy, px;
    logic signed [TW-1:0] t_sr, t_cr, t_sp, t_sy, t_cy, mag;
    logic                 clamped;
    logic [27:0]          mag28;
    logic [55:0]          sq_c;
    logic [SQW-1:0]       r_v, r_r, sq_bit, sq_rb;
    logic signed [XW-1:0] cor_y, cor_x;
    logic signed [AW-1:0] cor_ang;
    logic signed [OW-1:0] rnd, lim, conv, pitch_v;
    logic signed [OW-1:0] r_roll, r_pitch, r_yaw, r_prior;
    logic signed [DW-1:0] delta, delta_w;
    logic signed [33:0]   sum, diff, sum_sat, diff_sat;
    logic signed [31:0]   r_run, r_ref, eff_ref;
    logic                 r_started, r_ref_set;
    t_out                 r_out;

    // shared 16x16 multiplier
    always_comb begin
        mul_a = r_in.quat_w;
        mul_b = r_in.quat_x;
        case (i_cmd.idx)
            P_WX: begin mul_a = r_in.quat_w; mul_b = r_in.quat_x; end
            P_YZ: begin mul_a = r_in.quat_y; mul_b = r_in.quat_z; end
            P_XX: begin mul_a = r_in.quat_x; mul_b = r_in.quat_x; end
            P_YY: begin mul_a = r_in.quat_y; mul_b = r_in.quat_y; end
            P_WY: begin mul_a = r_in.quat_w; mul_b = r_in.quat_y; end
            P_ZX: begin mul_a = r_in.quat_z; mul_b = r_in.quat_x; end
            P_WZ: begin mul_a = r_in.quat_w; mul_b = r_in.quat_z; end
            P_XY: begin mul_a = r_in.quat_x; mul_b = r_in.quat_y; end
            P_ZZ: begin mul_a = r_in.quat_z; mul_b = r_in.quat_z; end
            default: begin mul_a = r_in.quat_w; mul_b = r_in.quat_x; end
        endcase
    end

    assign prod_c = mul_a * mul_b;
    assign px     = 33'(r_prod);

    always_comb begin
        n_a_sr = r_a_sr;
        n_a_cr = r_a_cr;
        n_a_sp = r_a_sp;
        n_a_sy = r_a_sy;
        n_a_cy = r_a_cy;
        case (r_pidx)
            P_WX, P_YZ: n_a_sr = r_a_sr + px;
            P_XX:       n_a_cr = r_a_cr + px;
            P_YY: begin
                n_a_cr = r_a_cr + px;
                n_a_cy = r_a_cy + px;
            end
            P_WY:       n_a_sp = r_a_sp + px;
            P_ZX:       n_a_sp = r_a_sp - px;
            P_WZ, P_XY: n_a_sy = r_a_sy + px;
            P_ZZ:       n_a_cy = r_a_cy + px;
            default: ;
        endcase
    end

    // q28 terms
    assign t_sr    = TW'(r_a_sr) <<< 1;
    assign t_cr    = ONE - (TW'(r_a_cr) <<< 1);
    assign t_sp    = TW'(r_a_sp) <<< 1;
    assign t_sy    = TW'(r_a_sy) <<< 1;
    assign t_cy    = ONE - (TW'(r_a_cy) <<< 1);
    assign clamped = (t_sp >= ONE) || (t_sp <= -ONE);
    assign mag     = (t_sp < 0) ? -t_sp : t_sp;
    assign mag28   = mag[27:0];
    assign sq_c    = mag28 * mag28;
    assign o_sts.clamped = clamped;

    // bit-pair square root of 2^56 - s^2
    assign sq_bit = SQW'(1) << (56 - 2 * int'(i_cmd.idx));
    assign sq_rb  = r_r + sq_bit;

    always_comb begin
        cor_y = XW'(t_sr);
        cor_x = XW'(t_cr);
        case (i_cmd.sel)
            A_ROLL: begin
                cor_y = XW'(t_sr);
                cor_x = XW'(t_cr);
            end
            A_PITCH: begin
                cor_y = XW'(t_sp);
                cor_x = XW'(r_r[28:0]);
            end
            default: begin
                cor_y = XW'(t_sy);
                cor_x = XW'(t_cy);
            end
        endcase
    end

    qey_cordic u_cordic (
        .i_clk  (i_clk),
        .i_load (i_cmd.cor_ld),
        .i_step (i_cmd.cor_step),
        .i_idx  (i_cmd.idx),
        .i_y    (cor_y),
        .i_x    (cor_x),
        .o_ang  (cor_ang)
    );

    // q16 to output units, round half up
    if (SH > 0) begin : g_rnd
        assign rnd = (OW'(cor_ang) + OW'(1 <<< (SH - 1))) >>> SH;
    end else begin : g_nornd
        assign rnd = OW'(cor_ang);
    end

    assign lim  = (i_cmd.sel == A_PITCH) ? A90 : A180;
    assign conv = (rnd > lim) ? lim : ((rnd < -lim) ? -lim : rnd);

    // unwrap across the seam
    always_comb begin
        delta = DW'(r_yaw) - DW'(r_prior);
        if (delta > DW'(A180)) begin
            delta_w = delta - (DW'(A180) <<< 1);
        end else if (delta < -DW'(A180)) begin
            delta_w = delta + (DW'(A180) <<< 1);
        end else begin
            delta_w = delta;
        end
        sum      = 34'(r_run) + 34'(delta_w);
        sum_sat  = (sum > S_MAX) ? S_MAX : ((sum < S_MIN) ? S_MIN : sum);
        eff_ref  = r_ref_set ? r_ref : r_run;
        diff     = 34'(eff_ref) - 34'(r_run);
        diff_sat = (diff > S_MAX) ? S_MAX : ((diff < S_MIN) ? S_MIN : diff);
        pitch_v  = clamped ? ((t_sp < 0) ? -A90 : A90) : r_pitch;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in   <= i_data;
            r_a_sr <= '0;
            r_a_cr <= '0;
            r_a_sp <= '0;
            r_a_sy <= '0;
            r_a_cy <= '0;
        end else if (i_cmd.acc_en) begin
            r_a_sr <= n_a_sr;
            r_a_cr <= n_a_cr;
            r_a_sp <= n_a_sp;
            r_a_sy <= n_a_sy;
            r_a_cy <= n_a_cy;
        end
        if (i_cmd.mul_en) begin
            r_prod <= prod_c;
            r_pidx <= i_cmd.idx;
        end
        if (i_cmd.sq_en) begin
            r_v <= SQW'(sq_c);
        end else if (i_cmd.sqrt_ld) begin
            r_v <= (SQW'(1) << 56) - r_v;
            r_r <= '0;
        end else if (i_cmd.sqrt_step) begin
            if (r_v >= sq_rb) begin
                r_v <= r_v - sq_rb;
                r_r <= (r_r >> 1) + sq_bit;
            end else begin
                r_r <= r_r >> 1;
            end
        end
        if (i_cmd.store_en) begin
            case (i_cmd.sel)
                A_ROLL:  r_roll  <= conv;
                A_PITCH: r_pitch <= conv;
                default: r_yaw   <= conv;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out.roll_angle    <= r_roll[16:0];
            r_out.pitch_angle   <= pitch_v[15:0];
            r_out.relative_yaw  <= diff_sat[31:0];
            r_out.pitch_clamped <= clamped;
        end
    end

    // yaw tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior   <= '0;
            r_run     <= '0;
            r_started <= 1'b0;
            r_ref     <= '0;
            r_ref_set <= 1'b0;
        end else begin
            if (i_cmd.upd_en) begin
                if (r_in.rezero_yaw) begin
                    r_ref <= r_run;
                end
                r_prior   <= r_yaw;
                r_started <= 1'b1;
                if (!r_started) begin
                    r_run <= 32'(r_yaw);
                end else begin
                    r_run <= sum_sat[31:0];
                end
            end
            if (i_cmd.out_load && !r_ref_set) begin
                r_ref     <= r_run;
                r_ref_set <= 1'b1;
            end
        end
    end

    assign o_data = r_out;

endmodule

[sv/quaternion_to_euler_yaw_unwrap.sv]
// top level: quaternion to roll, pitch and unwrapped relative yaw
//
//   channel   direction   handshake               beat
//   input     in          i_valid / o_ready       t_in: quaternion q2.14, rezero flag
//   result    out         o_valid / i_ready       t_out: roll, pitch, relative yaw, clamp
//
// a result follows the products, square root, three cordic passes and yaw update; when pitch
// clamps, the square root and pitch pass are skipped; the next beat can be taken in the cycle
// that the result turns valid; the time is set by the one shared cordic and the 29-step square root
// synchronous active-low reset clears the sequencer, result valid and yaw tracking
// the result register is separate, so a new beat is taken while a result waits;
// only the last step stalls when the previous result has not been taken
module quaternion_to_euler_yaw_unwrap #(
    parameter int CORDIC_STEPS    = qey_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = qey_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  qey_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output qey_pkg::t_out o_data
);
    import qey_pkg::*;

    // command bundle from sequencer to datapath, status back
    t_cmd cmd;
    t_sts sts;

    // sequencer: products, optional square root, roll/pitch/yaw cordic, yaw update
    qey_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath: shared multiplier, square root, cordic and yaw tracking state
    qey_dp #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_data  (i_data),
        .o_sts   (sts),
        .o_data  (o_data)
    );

endmodule

[sv/qey_chk.sv]
// port-level checker for the euler angle block, bound to the top level
`include "quaternion_to_euler_yaw_unwrap_macros.svh"

module qey_chk #(
    parameter int ANGLE_FRAC_BITS = qey_pkg::ANGLE_FRAC_BITS_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input qey_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_ready,
    input qey_pkg::t_out o_data
);
    localparam logic signed [15:0] P90 = 16'(90 <<< ANGLE_FRAC_BITS);
    localparam logic signed [15:0] N90 = -P90;

    `QEY_NEXT(a_valid_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "result beat dropped")
    `QEY_NEXT(a_data_hold, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_data), "result moved")
    `QEY_NEXT(a_one_item, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "second beat taken")
    `QEY_SAME(a_clamp_val, i_clk, i_rst_n, o_valid && o_data.pitch_clamped, o_data.pitch_angle == P90 || o_data.pitch_angle == N90, "clamped pitch off")
    `QEY_ALWAYS_NEXT(a_reset, i_clk, !i_rst_n, !o_valid && o_ready, "reset state wrong")

endmodule

bind quaternion_to_euler_yaw_unwrap qey_chk #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_qey_chk (.*);
